// ===== design/apr_pkg.sv =====
package apr_pkg;

   localparam int COORD_BITS      = 16;
   localparam int ANGLE_BITS      = 16;
   localparam int CORDIC_STEPS    = 24;
   localparam int STEPS_PER_STAGE = 2;
   localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
   localparam int TRIG_FRAC       = 30;
   localparam int TRIG_W          = 34;
   localparam int ZW              = 32;
   localparam int PROD_W          = COORD_BITS + TRIG_W;
   localparam int SUM_W           = PROD_W + 1;
   localparam int RND_W           = SUM_W - TRIG_FRAC;

   localparam logic [1:0] AXIS_X    = 2'd0;
   localparam logic [1:0] AXIS_Y    = 2'd1;
   localparam logic [1:0] AXIS_Z    = 2'd2;
   localparam logic [1:0] AXIS_NONE = 2'd3;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   // inverse cordic gain, Q4.30
   localparam logic signed [TRIG_W-1:0] CORDIC_X0 = TRIG_W'(32'h26DD3B6A);
   localparam logic [ZW-1:0] QUAD_HALF = ZW'(32'h2000_0000);
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'sd1 <<< (TRIG_FRAC - 1));
   localparam logic signed [RND_W-1:0] SAT_MAX =
      RND_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [RND_W-1:0] SAT_MIN = -SAT_MAX - RND_W'(1);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] in_x;
      logic signed [COORD_BITS-1:0] in_y;
      logic signed [COORD_BITS-1:0] in_z;
      logic [1:0]                   axis_code;
      logic [ANGLE_BITS-1:0]        angle;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic signed [COORD_BITS-1:0] out_z;
   } rsp_type;

   // coordinates riding alongside the cordic
   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic [1:0]                   axis;
   } side_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] x;
      logic signed [TRIG_W-1:0] y;
      logic signed [ZW-1:0]     z;
   } cordic_type;

   function automatic logic signed [ZW-1:0] atan_at(input int unsigned i);
      logic signed [ZW-1:0] r;
      case (i)
         0:       r = ZW'(32'h20000000);
         1:       r = ZW'(32'h12E4051E);
         2:       r = ZW'(32'h09FB385B);
         3:       r = ZW'(32'h051111D4);
         4:       r = ZW'(32'h028B0D43);
         5:       r = ZW'(32'h0145D7E1);
         6:       r = ZW'(32'h00A2F61E);
         7:       r = ZW'(32'h00517C55);
         8:       r = ZW'(32'h0028BE53);
         9:       r = ZW'(32'h00145F2F);
         10:      r = ZW'(32'h000A2F98);
         11:      r = ZW'(32'h000517CC);
         12:      r = ZW'(32'h00028BE6);
         13:      r = ZW'(32'h000145F3);
         14:      r = ZW'(32'h0000A2FA);
         15:      r = ZW'(32'h0000517D);
         16:      r = ZW'(32'h000028BE);
         17:      r = ZW'(32'h0000145F);
         18:      r = ZW'(32'h00000A30);
         19:      r = ZW'(32'h00000518);
         20:      r = ZW'(32'h0000028C);
         21:      r = ZW'(32'h00000146);
         22:      r = ZW'(32'h000000A3);
         23:      r = ZW'(32'h00000051);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic cordic_type cordic_iter(input cordic_type v, input int unsigned i);
      cordic_type           r;
      logic signed [TRIG_W-1:0] xs;
      logic signed [TRIG_W-1:0] ys;
      xs = v.x >>> i;
      ys = v.y >>> i;
      if (!v.z[ZW-1]) begin
         r.x = v.x - ys;
         r.y = v.y + xs;
         r.z = v.z - atan_at(i);
      end else begin
         r.x = v.x + ys;
         r.y = v.y - xs;
         r.z = v.z + atan_at(i);
      end
      return r;
   endfunction

   // round half up at bit 30, then clamp to the coordinate range
   function automatic logic signed [COORD_BITS-1:0] round_sat(input logic signed [SUM_W-1:0] acc);
      logic signed [SUM_W-1:0] t;
      logic signed [RND_W-1:0] v;
      logic signed [COORD_BITS-1:0] r;
      t = acc + ROUND_HALF;
      v = t[SUM_W-1:TRIG_FRAC];
      if (v > SAT_MAX) begin
         r = SAT_MAX[COORD_BITS-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[COORD_BITS-1:0];
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// ===== design/apr_cordic.sv =====
module apr_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [apr_pkg::ANGLE_BITS-1:0]      in_angle,
   input  apr_pkg::side_type                   in_side,
   output logic                                out_valid,
   output apr_pkg::cordic_type                 out_vec,
   output logic [1:0]                          out_quad,
   output apr_pkg::side_type                   out_side
);

   localparam int NS = apr_pkg::CORDIC_STAGES;

   logic                 valid_ff [0:NS];
   apr_pkg::cordic_type  vec_ff   [0:NS];
   logic [1:0]           quad_ff  [0:NS];
   apr_pkg::side_type    side_ff  [0:NS];

   // quadrant fold: residual angle lands in [-45, +45) degrees
   logic [apr_pkg::ZW-1:0] ang_full;
   logic [apr_pkg::ZW-1:0] ang_bias;
   logic [apr_pkg::ZW-1:0] ang_rest;
   logic [1:0]             quad_in;
   apr_pkg::cordic_type    vec0_in;

   always_comb begin
      ang_full = apr_pkg::ZW'(in_angle) << (apr_pkg::ZW - apr_pkg::ANGLE_BITS);
      ang_bias = ang_full + apr_pkg::QUAD_HALF;
      quad_in  = ang_bias[apr_pkg::ZW-1 -: 2];
      ang_rest = ang_full - {quad_in, {(apr_pkg::ZW-2){1'b0}}};
      vec0_in.x = apr_pkg::CORDIC_X0;
      vec0_in.y = '0;
      vec0_in.z = signed'(ang_rest);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff[0]  <= vec0_in;
         quad_ff[0] <= quad_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_stage
      apr_pkg::cordic_type vec_in;

      always_comb begin
         vec_in = vec_ff[k];
         for (int j = 0; j < apr_pkg::STEPS_PER_STAGE; j++) begin
            vec_in = apr_pkg::cordic_iter(vec_in, k * apr_pkg::STEPS_PER_STAGE + j);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            vec_ff[k+1]  <= vec_in;
            quad_ff[k+1] <= quad_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[NS];
   assign out_vec   = vec_ff[NS];
   assign out_quad  = quad_ff[NS];
   assign out_side  = side_ff[NS];

endmodule

// ===== design/apr_rotate.sv =====
module apr_rotate (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  apr_pkg::cordic_type  in_vec,
   input  logic [1:0]           in_quad,
   input  apr_pkg::side_type    in_side,
   output logic                 out_valid,
   output apr_pkg::rsp_type     out_data
);

   localparam int CW = apr_pkg::COORD_BITS;
   localparam int TW = apr_pkg::TRIG_W;
   localparam int PW = apr_pkg::PROD_W;
   localparam int SW = apr_pkg::SUM_W;

   // stage a: quadrant unfold and operand pick
   logic signed [TW-1:0] cos_in, sin_in;
   logic signed [CW-1:0] opa_in, opb_in, pass_in;
   logic signed [TW-1:0] cos_ff, sin_ff;
   logic signed [CW-1:0] opa_ff, opb_ff, pass_ff;
   logic [1:0]           axis_ff;
   logic                 map_valid_ff;

   always_comb begin
      case (in_quad)
         apr_pkg::QUAD_0: begin cos_in = in_vec.x;  sin_in = in_vec.y;  end
         apr_pkg::QUAD_1: begin cos_in = -in_vec.y; sin_in = in_vec.x;  end
         apr_pkg::QUAD_2: begin cos_in = -in_vec.x; sin_in = -in_vec.y; end
         default:         begin cos_in = in_vec.y;  sin_in = -in_vec.x; end
      endcase
   end

   // a*c - b*s and a*s + b*c cover all three axes
   always_comb begin
      case (in_side.axis)
         apr_pkg::AXIS_X: begin
            opa_in = in_side.y; opb_in = in_side.z; pass_in = in_side.x;
         end
         apr_pkg::AXIS_Y: begin
            opa_in = in_side.z; opb_in = in_side.x; pass_in = in_side.y;
         end
         apr_pkg::AXIS_Z: begin
            opa_in = in_side.x; opb_in = in_side.y; pass_in = in_side.z;
         end
         default: begin
            opa_in = '0; opb_in = '0; pass_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= 1'b0;
      end else if (en) begin
         map_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff  <= cos_in;
         sin_ff  <= sin_in;
         opa_ff  <= opa_in;
         opb_ff  <= opb_in;
         pass_ff <= pass_in;
         axis_ff <= in_side.axis;
      end
   end

   // stage b: four products
   logic signed [PW-1:0] ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [CW-1:0] pass2_ff;
   logic [1:0]           axis2_ff;
   logic                 mul_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= map_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ac_ff    <= PW'(opa_ff) * PW'(cos_ff);
         bs_ff    <= PW'(opb_ff) * PW'(sin_ff);
         as_ff    <= PW'(opa_ff) * PW'(sin_ff);
         bc_ff    <= PW'(opb_ff) * PW'(cos_ff);
         pass2_ff <= pass_ff;
         axis2_ff <= axis_ff;
      end
   end

   // final sums, rounding and clamping feed the output register
   logic signed [SW-1:0] dif_sum, add_sum;
   logic signed [CW-1:0] dif_r, add_r;

   always_comb begin
      dif_sum = SW'(ac_ff) - SW'(bs_ff);
      add_sum = SW'(as_ff) + SW'(bc_ff);
      dif_r   = apr_pkg::round_sat(dif_sum);
      add_r   = apr_pkg::round_sat(add_sum);
      case (axis2_ff)
         apr_pkg::AXIS_X: begin
            out_data.out_x = pass2_ff; out_data.out_y = dif_r; out_data.out_z = add_r;
         end
         apr_pkg::AXIS_Y: begin
            out_data.out_x = add_r; out_data.out_y = pass2_ff; out_data.out_z = dif_r;
         end
         apr_pkg::AXIS_Z: begin
            out_data.out_x = dif_r; out_data.out_y = add_r; out_data.out_z = pass2_ff;
         end
         default: begin
            out_data.out_x = '0; out_data.out_y = '0; out_data.out_z = '0;
         end
      endcase
   end

   assign out_valid = mul_valid_ff;

endmodule

// ===== design/axis_point_rotator_unit.sv =====
// channel    ports                                 direction  payload
// request    req_valid, req_stall, req_data        in         apr_pkg::req_type
// response   rsp_valid, rsp_stall, rsp_data        out        apr_pkg::rsp_type
//
// one request per cycle while req_stall is low; from request accept to rsp_valid
// a request passes the fold stage, 12 cordic stages of two iterations each,
// the operand stage, the multiply stage and the output register.
// reset is synchronous and clears only the valid bits of the pipeline.
// a stalled response parks the next result in a skid register; while it is
// full the whole pipeline holds and req_stall is high.
module axis_point_rotator_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  apr_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output apr_pkg::rsp_type  rsp_data
);

   logic                pipe_en;
   logic                cdc_valid;
   apr_pkg::cordic_type cdc_vec;
   logic [1:0]          cdc_quad;
   apr_pkg::side_type   cdc_side;
   apr_pkg::side_type   req_side;
   logic                pipe_valid;
   apr_pkg::rsp_type    pipe_data;

   logic             rsp_valid_ff, rsp_valid_in;
   apr_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             skid_valid_ff, skid_valid_in;
   apr_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             slot_free;

   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign req_side.x    = req_data.in_x;
   assign req_side.y    = req_data.in_y;
   assign req_side.z    = req_data.in_z;
   assign req_side.axis = req_data.axis_code;

   apr_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_valid),
      .in_angle  (req_data.angle),
      .in_side   (req_side),
      .out_valid (cdc_valid),
      .out_vec   (cdc_vec),
      .out_quad  (cdc_quad),
      .out_side  (cdc_side)
   );

   apr_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (cdc_valid),
      .in_vec    (cdc_vec),
      .in_quad   (cdc_quad),
      .in_side   (cdc_side),
      .out_valid (pipe_valid),
      .out_data  (pipe_data)
   );

   // output register with skid behind it
   always_comb begin
      slot_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (slot_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = pipe_valid;
            rsp_data_in  = pipe_data;
         end
      end else if (pipe_valid && pipe_en) begin
         skid_valid_in = 1'b1;
         skid_data_in  = pipe_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a result while the output register is empty");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall && pipe_valid))
      else $error("skid filled without a stalled response and a pipeline result");

   a_pipe_hold: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pipe_valid |=> pipe_valid)
      else $error("pipeline result dropped while the skid was full");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import apr_pkg::*;

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          RANDOM_ITEMS = 850;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          LONG_HOLD    = 300;
   localparam int          HOLD_AFTER   = 300;
   localparam int          TRIG_SHIFT   = 30;
   localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   class rotated_point_check;
      rsp_type     expected_points[$];
      longint      atan_steps[24];
      int unsigned mismatch_count;
      int unsigned checked_count;

      function new();
         atan_steps = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
            64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
            64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
         mismatch_count = 0;
         checked_count  = 0;
      endfunction

      // cosine and sine with 30 fraction bits; angle folded to +-45 degrees first
      function void sin_cos(input logic [ANGLE_BITS-1:0] angle,
                            output longint c, output longint s);
         logic [31:0] turn;
         logic [31:0] shifted;
         logic [31:0] residue;
         logic [1:0]  quad;
         longint      xr;
         longint      yr;
         longint      zr;
         longint      nx;
         longint      ny;
         turn    = 32'(angle) << (32 - ANGLE_BITS);
         shifted = turn + EIGHTH_TURN;
         quad    = shifted[31:30];
         residue = turn - {quad, 30'd0};
         zr      = longint'($signed(residue));
         xr      = 64'h26DD3B6A;
         yr      = 0;
         for (int i = 0; i < 24; i++) begin
            if (zr >= 0) begin
               nx = xr - (yr >>> i);
               ny = yr + (xr >>> i);
               zr = zr - atan_steps[i];
            end else begin
               nx = xr + (yr >>> i);
               ny = yr - (xr >>> i);
               zr = zr + atan_steps[i];
            end
            xr = nx;
            yr = ny;
         end
         case (quad)
            QUAD_0: begin c = xr;  s = yr;  end
            QUAD_1: begin c = -yr; s = xr;  end
            QUAD_2: begin c = -xr; s = -yr; end
            default: begin c = yr; s = -xr; end
         endcase
      endfunction

      function logic signed [COORD_BITS-1:0] round_clamp(input longint acc);
         longint v;
         v = (acc + (64'sd1 <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
         if (v > longint'(COORD_MAX)) v = longint'(COORD_MAX);
         if (v < longint'(COORD_MIN)) v = longint'(COORD_MIN);
         return COORD_BITS'(v);
      endfunction

      function rsp_type predict_point(input req_type p);
         rsp_type r;
         longint  c;
         longint  s;
         longint  x;
         longint  y;
         longint  z;
         sin_cos(p.angle, c, s);
         x = longint'(p.in_x);
         y = longint'(p.in_y);
         z = longint'(p.in_z);
         case (p.axis_code)
            AXIS_X: begin
               r.out_x = p.in_x;
               r.out_y = round_clamp(y * c - z * s);
               r.out_z = round_clamp(y * s + z * c);
            end
            AXIS_Y: begin
               r.out_x = round_clamp(x * c + z * s);
               r.out_y = p.in_y;
               r.out_z = round_clamp(-(x * s) + z * c);
            end
            AXIS_Z: begin
               r.out_x = round_clamp(x * c - y * s);
               r.out_y = round_clamp(x * s + y * c);
               r.out_z = p.in_z;
            end
            default: begin
               r = '0;
            end
         endcase
         return r;
      endfunction

      function void note_request(input req_type p);
         expected_points.insert(expected_points.size(), predict_point(p));
      endfunction

      function void check_point(input rsp_type got);
         rsp_type want;
         checked_count++;
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected point (%0d,%0d,%0d)", got.out_x, got.out_y, got.out_z);
            return;
         end
         want = expected_points.pop_front();
         if (got.out_x !== want.out_x || got.out_y !== want.out_y
             || got.out_z !== want.out_z) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("point mismatch: expected (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                        want.out_x, want.out_y, want.out_z,
                        got.out_x, got.out_y, got.out_z);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rotated_point_check point_check = new();
   int unsigned        cycle_count = 0;
   int unsigned        sender_calm = 0;

   axis_point_rotator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned gap_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] pick_coord();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return COORD_MIN;
      if (r == 1) return COORD_MAX;
      if (r < 9) return COORD_BITS'($urandom_range(0, 16383) - 8192);
      return COORD_BITS'($urandom);
   endfunction

   function automatic req_type make_point(input int x, input int y, input int z,
                                          input logic [1:0] axis,
                                          input logic [ANGLE_BITS-1:0] angle);
      req_type p;
      p.in_x      = COORD_BITS'(x);
      p.in_y      = COORD_BITS'(y);
      p.in_z      = COORD_BITS'(z);
      p.axis_code = axis;
      p.angle     = angle;
      return p;
   endfunction

   task automatic send_point(input req_type p);
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      point_check.note_request(p);
   endtask

   task automatic pause_sender();
      int unsigned gap;
      gap = 0;
      if (sender_calm > 0) begin
         sender_calm--;
      end else if ($urandom_range(0, 29) == 0) begin
         sender_calm = $urandom_range(20, 60);
      end else if ($urandom_range(0, 3) == 0) begin
         gap = gap_length();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // response side: random stalls, calm stretches, and one long hold-off
   initial begin
      int unsigned stall_left;
      int unsigned calm_left;
      bit          long_hold_done;
      stall_left     = 0;
      calm_left      = 0;
      long_hold_done = 0;
      rsp_stall      <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) point_check.check_point(rsp_data);
         if (stall_left == 0 && calm_left == 0) begin
            if (!long_hold_done && point_check.checked_count >= HOLD_AFTER) begin
               stall_left     = LONG_HOLD;
               long_hold_done = 1;
            end else if ($urandom_range(0, 9) < 3) begin
               stall_left = gap_length();
            end else if ($urandom_range(0, 19) == 0) begin
               calm_left = $urandom_range(20, 80);
            end
         end
         if (calm_left > 0) begin
            calm_left--;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      req_type     p;
      int unsigned r;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners: extremes, each axis, quadrant boundaries, saturation, invalid axis
      send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX, AXIS_X, 16'h0000));
      send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN, AXIS_Y, 16'h0000));
      send_point(make_point(4096, 0, 0, AXIS_Z, 16'h4000));
      send_point(make_point(4096, 8192, -4096, AXIS_X, 16'h8000));
      send_point(make_point(-4096, 2048, 12288, AXIS_Y, 16'hC000));
      send_point(make_point(COORD_MAX, COORD_MAX, 0, AXIS_Z, 16'h2000));
      send_point(make_point(COORD_MIN, COORD_MIN, 5, AXIS_Z, 16'h2000));
      pause_sender();
      send_point(make_point(COORD_MIN, 0, 0, AXIS_Z, 16'h8000));
      send_point(make_point(0, COORD_MIN, COORD_MAX, AXIS_X, 16'h1FFF));
      send_point(make_point(COORD_MAX, 1, COORD_MIN, AXIS_Y, 16'hFFFF));
      send_point(make_point(1234, -5678, 910, AXIS_NONE, 16'h3000));
      send_point(make_point(COORD_MIN, COORD_MAX, -1, AXIS_NONE, 16'hFFFF));
      send_point(make_point(-1, -1, -1, AXIS_X, 16'h6000));
      pause_sender();
      send_point(make_point(1, 1, 1, AXIS_Y, 16'hE000));
      send_point(make_point(0, 0, 0, AXIS_Z, 16'hA000));
      send_point(make_point(COORD_MAX, COORD_MIN, COORD_MAX, AXIS_Y, 16'h2000));
      send_point(make_point(COORD_MIN, COORD_MAX, COORD_MIN, AXIS_X, 16'hDFFF));
      send_point(make_point(3, -3, 2048, AXIS_Z, 16'h0001));
      send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN, AXIS_Y, 16'h8000));
      send_point(make_point(COORD_MAX, COORD_MIN, 7, AXIS_Z, 16'h7FFF));
      send_point(make_point(COORD_MIN, COORD_MAX, COORD_MIN, AXIS_Z, 16'h5FFF));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pause_sender();
         r = $urandom_range(0, 11);
         p.in_x      = pick_coord();
         p.in_y      = pick_coord();
         p.in_z      = pick_coord();
         p.axis_code = (r == 0) ? AXIS_NONE : 2'(r % 3);
         p.angle     = ANGLE_BITS'($urandom);
         send_point(p);
      end
      req_valid <= 1'b0;

      while (point_check.expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (point_check.mismatch_count == 0 && point_check.expected_points.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
